// ===== rtl/core/sha512_pkg.sv =====
// ----------------------------------------------------------------------------
// sha512_pkg
// Shared types, constants and round functions for the SHA-512 engine.
// ----------------------------------------------------------------------------
package sha512_pkg;

    localparam int WordW  = 64;
    localparam int Rounds = 80;

    // Command from the front part to the compression core.
    typedef enum logic [1:0] {
        CMD_WORD = 2'd0,   // full word into the block
        CMD_LAST = 2'd1    // final word, already masked and marked
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [63:0] word;
        logic [3:0]  nbytes;  // saturated 0..8 on last word
    } t_qitem;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_ROUND = 3'd1,
        ST_ADD   = 3'd2,
        ST_PAD   = 3'd3,
        ST_OUT   = 3'd4
    } t_state;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] init_h(input logic [2:0] i);
        case (i)
            3'd0:    init_h = 64'h6a09e667f3bcc908;
            3'd1:    init_h = 64'hbb67ae8584caa73b;
            3'd2:    init_h = 64'h3c6ef372fe94f82b;
            3'd3:    init_h = 64'ha54ff53a5f1d36f1;
            3'd4:    init_h = 64'h510e527fade682d1;
            3'd5:    init_h = 64'h9b05688c2b3e6c1f;
            3'd6:    init_h = 64'h1f83d9abfb41bd6b;
            default: init_h = 64'h5be0cd19137e2179;
        endcase
    endfunction

    function automatic logic [63:0] round_k(input logic [6:0] i);
        logic [63:0] k [0:79];
        k = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
        round_k = k[i];
    endfunction

endpackage

// ===== rtl/core/sha512_front.sv =====
// ----------------------------------------------------------------------------
// sha512_front
// Input side: accepts items, saturates and masks the last word, adds the
// 0x80 marker and queues a command for the compression core.
// ----------------------------------------------------------------------------
module sha512_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic [63:0]         i_message_word,
    input  logic [3:0]          i_valid_bytes,
    input  logic                i_last_word,
    output logic                o_q_valid,
    output sha512_pkg::t_qitem  o_q_item,
    input  logic                i_q_pop
);
    import sha512_pkg::*;

    // two-entry queue
    t_qitem     r_mem [0:1];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    logic       w_acc;
    logic [3:0] w_n;
    logic [63:0] w_keep, w_mark;
    t_qitem     w_item;

    assign o_full    = (r_cnt == 2'd2);
    assign w_acc     = i_push && !o_full;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];

    always_comb begin
        w_n    = (i_valid_bytes > 4'd8) ? 4'd8 : i_valid_bytes;
        w_keep = (w_n == 4'd0) ? 64'd0 : ~(64'hFFFFFFFFFFFFFFFF >> {w_n, 3'b000});
        // marker lands in the byte after the valid ones; none when word is full
        w_mark = (w_n == 4'd8) ? 64'd0 : (64'h80 << (7'd56 - {w_n[2:0], 3'b000}));
        w_item.cmd    = i_last_word ? CMD_LAST : CMD_WORD;
        w_item.nbytes = w_n;
        w_item.word   = i_last_word ? ((i_message_word & w_keep) | w_mark) : i_message_word;
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_mem[r_wp] <= w_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_acc) r_wp <= ~r_wp;
            if (i_q_pop && o_q_valid) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_acc} - {1'b0, i_q_pop && o_q_valid};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |=> r_cnt != 2'd0 || $past(i_q_pop))
        else $error("queue count jumped");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> o_q_valid) else $error("pop from empty queue");

endmodule

// ===== rtl/core/sha512_core.sv =====
// ----------------------------------------------------------------------------
// sha512_core
// Back side: collects block words, runs 80 rounds one per cycle with a
// 16-word rolling schedule, pads the final block(s) and streams the digest.
// ----------------------------------------------------------------------------
module sha512_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  sha512_pkg::t_qitem  i_q_item,
    output logic                o_q_pop,
    output logic                o_empty,
    input  logic                i_pop,
    output logic [63:0]         o_digest_word,
    output logic                o_digest_last
);
    import sha512_pkg::*;

    t_state      r_st, n_st;
    logic [63:0] r_h [0:7];
    logic [63:0] r_v [0:7];
    logic [63:0] r_w [0:15];      // rolling schedule, r_w[0] is W[t]
    logic [3:0]  r_pos;
    logic [63:0] r_bytes;
    logic [6:0]  r_rnd;
    logic        r_fin;           // padding in progress
    logic        r_lenp;          // length words belong in the current block
    logic        r_mk;            // full last word, 0x80 marker word still owed
    logic [2:0]  r_oi;

    logic [63:0] w_new, w_t1, w_t2, w_s0, w_s1, w_pad, w_bytes_nx;
    logic        w_store, w_take;

    assign o_empty       = (r_st != ST_OUT);
    assign o_digest_word = r_h[r_oi];
    assign o_digest_last = (r_oi == 3'd7);

    always_comb begin
        w_s0  = rotr(r_w[1], 1) ^ rotr(r_w[1], 8) ^ (r_w[1] >> 7);
        w_s1  = rotr(r_w[14], 19) ^ rotr(r_w[14], 61) ^ (r_w[14] >> 6);
        w_new = w_s1 + r_w[9] + w_s0 + r_w[0];
        w_t1  = r_v[7] + (rotr(r_v[4], 14) ^ rotr(r_v[4], 18) ^ rotr(r_v[4], 41))
              + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + round_k(r_rnd) + r_w[0];
        w_t2  = (rotr(r_v[0], 28) ^ rotr(r_v[0], 34) ^ rotr(r_v[0], 39))
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        // pad word: marker after a full last word, zeros, then bit length in 14 and 15
        if (r_mk)                          w_pad = {8'h80, 56'd0};
        else if (r_lenp && r_pos == 4'd14) w_pad = {61'd0, r_bytes[63:61]};
        else if (r_lenp && r_pos == 4'd15) w_pad = {r_bytes[60:0], 3'b000};
        else                               w_pad = 64'd0;
        w_bytes_nx = r_bytes + ((i_q_item.cmd == CMD_LAST) ?
                     {60'd0, i_q_item.nbytes} : 64'd8);
    end

    always_comb begin
        n_st    = r_st;
        w_take  = 1'b0;
        w_store = 1'b0;
        case (r_st)
            ST_IDLE: begin
                if (i_q_valid) begin
                    w_take  = 1'b1;
                    w_store = 1'b1;
                    if (r_pos == 4'd15) n_st = ST_ROUND;
                    else if (i_q_item.cmd == CMD_LAST) n_st = ST_PAD;
                end
            end
            ST_PAD: begin
                w_store = 1'b1;
                if (r_pos == 4'd15) n_st = ST_ROUND;
            end
            ST_ROUND: if (r_rnd == 7'(Rounds - 1)) n_st = ST_ADD;
            ST_ADD: begin
                if (!r_fin) n_st = ST_IDLE;
                else if (r_lenp) n_st = ST_OUT;
                else n_st = ST_PAD;
            end
            ST_OUT: if (i_pop && r_oi == 3'd7) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end
    assign o_q_pop = w_take;

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_w[r_pos] <= (r_st == ST_IDLE) ? i_q_item.word : w_pad;
        end
        if (r_st == ST_ROUND) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
            r_w[15] <= w_new;
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= w_t1 + w_t2;
        end else begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end
        if (!i_rst_n) begin
            r_st    <= ST_IDLE;
            r_pos   <= 4'd0;
            r_bytes <= 64'd0;
            r_rnd   <= 7'd0;
            r_fin   <= 1'b0;
            r_lenp  <= 1'b0;
            r_mk    <= 1'b0;
            r_oi    <= 3'd0;
            for (int i = 0; i < 8; i++) r_h[i] <= init_h(3'(i));
        end else begin
            r_st <= n_st;
            if (w_store) r_pos <= r_pos + 4'd1;
            if (w_take) begin
                r_bytes <= w_bytes_nx;
                if (i_q_item.cmd == CMD_LAST) begin
                    r_fin <= 1'b1;
                    r_mk  <= (i_q_item.nbytes == 4'd8);
                    // length needs two free words after this word (and the marker)
                    r_lenp <= (i_q_item.nbytes == 4'd8) ? (r_pos <= 4'd12)
                                                         : (r_pos <= 4'd13);
                end
            end
            if (r_st == ST_PAD) r_mk <= 1'b0;
            if (r_st == ST_ROUND) r_rnd <= r_rnd + 7'd1;
            else r_rnd <= 7'd0;
            if (r_st == ST_ADD) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                if (r_fin) r_lenp <= 1'b1;
            end
            if (r_st == ST_OUT && i_pop) begin
                r_oi <= r_oi + 3'd1;
                if (r_oi == 3'd7) begin
                    r_fin   <= 1'b0;
                    r_lenp  <= 1'b0;
                    r_bytes <= 64'd0;
                    for (int i = 0; i < 8; i++) r_h[i] <= init_h(3'(i));
                end
            end
        end
    end

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> r_st == ST_IDLE) else $error("take outside idle");
    a_out_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == ST_OUT |-> r_pos == 4'd0) else $error("digest with partial block");
    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == ST_ROUND && r_rnd == 7'd79 |=> r_st == ST_ADD)
        else $error("round count slip");

endmodule

// ===== rtl/core/sha512_hash_engine_top.sv =====
// ----------------------------------------------------------------------------
// sha512_hash_engine_top
// SHA-512 engine over a stream of big-endian 64-bit message words.
// ----------------------------------------------------------------------------
// Input channel: i_push / o_full carry message words; i_last_word marks the
// final word, whose i_valid_bytes (0..8, larger taken as 8) high bytes count.
// Output channel: o_empty / i_pop give eight digest words, word 0 first,
// o_digest_last set on the eighth.
// A two-entry queue decouples input from the compression core. The core
// takes one word per cycle while idle and a word is queued; every 16th
// word starts a block of 80 rounds at one round per cycle, then an add
// into the chain; no word is taken while a block runs.
// On the last word the core writes padding one word per cycle and runs one
// or two more blocks before the digest appears.
// The digest is held while o_empty is low and i_pop is low; no new message
// is taken until all eight words have been popped, input then backs up in
// the queue and o_full rises.
// Reset (synchronous, i_rst_n low) loads the initial hash and clears counts.
// ----------------------------------------------------------------------------
module sha512_hash_engine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [63:0] i_message_word,
    input  logic [3:0]  i_valid_bytes,
    input  logic        i_last_word,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [63:0] o_digest_word,
    output logic        o_digest_last
);
    import sha512_pkg::*;

    logic   w_q_valid, w_q_pop;
    t_qitem w_q_item;

    sha512_front u_front (
        .i_clk, .i_rst_n, .i_push, .o_full, .i_message_word, .i_valid_bytes,
        .i_last_word, .o_q_valid(w_q_valid), .o_q_item(w_q_item), .i_q_pop(w_q_pop)
    );

    sha512_core u_core (
        .i_clk, .i_rst_n, .i_q_valid(w_q_valid), .i_q_item(w_q_item),
        .o_q_pop(w_q_pop), .o_empty, .i_pop, .o_digest_word, .o_digest_last
    );

endmodule

// ===== tb/sha512_digest_board.sv =====
// ----------------------------------------------------------------------------
// sha512_digest_board
// Digest predictor and scoreboard for the SHA-512 engine testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class sha512_digest_board;

    logic [63:0] chain [8];
    logic [63:0] blk [16];
    int unsigned pos;
    logic [63:0] nbytes_total;
    logic [63:0] digest_q [$];
    logic        last_q [$];
    int unsigned errors;

    function new();
        errors = 0;
        digest_q.delete();
        last_q.delete();
        clear_msg();
    endfunction

    function void clear_msg();
        chain[0] = 64'h6a09e667f3bcc908; chain[1] = 64'hbb67ae8584caa73b;
        chain[2] = 64'h3c6ef372fe94f82b; chain[3] = 64'ha54ff53a5f1d36f1;
        chain[4] = 64'h510e527fade682d1; chain[5] = 64'h9b05688c2b3e6c1f;
        chain[6] = 64'h1f83d9abfb41bd6b; chain[7] = 64'h5be0cd19137e2179;
        pos = 0;
        nbytes_total = '0;
    endfunction

    function logic [63:0] ror(logic [63:0] x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function void compress();
        logic [63:0] w [80];
        logic [63:0] v [8];
        logic [63:0] t1, t2, e, a;
        logic [63:0] kc [80];
        kc = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
        for (int i = 0; i < 16; i++) w[i] = blk[i];
        for (int i = 16; i < 80; i++)
            w[i] = (ror(w[i-2], 19) ^ ror(w[i-2], 61) ^ (w[i-2] >> 6)) + w[i-7]
                 + (ror(w[i-15], 1) ^ ror(w[i-15], 8) ^ (w[i-15] >> 7)) + w[i-16];
        for (int i = 0; i < 8; i++) v[i] = chain[i];
        for (int i = 0; i < 80; i++) begin
            e = v[4];
            a = v[0];
            t1 = v[7] + (ror(e, 14) ^ ror(e, 18) ^ ror(e, 41))
               + ((e & v[5]) ^ (~e & v[6])) + kc[i] + w[i];
            t2 = (ror(a, 28) ^ ror(a, 34) ^ ror(a, 39))
               + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain[i] += v[i];
    endfunction

    function void absorb(logic [63:0] w);
        blk[pos] = w;
        pos = (pos + 1) % 16;
        if (pos == 0) compress();
    endfunction

    // Called for every accepted input item.
    function void note_word(logic [63:0] word, logic [3:0] vb, logic last);
        int unsigned n;
        logic [63:0] keep;
        if (!last) begin
            nbytes_total += 64'd8;
            absorb(word);
            return;
        end
        n = (vb > 4'd8) ? 8 : vb;
        nbytes_total += 64'(n);
        if (n == 8) begin
            absorb(word);
            absorb(64'h80 << 56);
        end else begin
            keep = (n == 0) ? 64'd0 : ~64'd0 << (64 - 8 * n);
            absorb((word & keep) | (64'h80 << (56 - 8 * n)));
        end
        // length needs two free words; else close this block first
        if (pos > 14) while (pos != 0) absorb('0);
        while (pos < 14) absorb('0);
        absorb(nbytes_total >> 61);
        absorb(nbytes_total << 3);
        for (int k = 0; k < 8; k++) begin
            digest_q.push_back(chain[k]);
            last_q.push_back(k == 7);
        end
        clear_msg();
    endfunction

    function void check_digest(logic [63:0] dw, logic dl);
        logic [63:0] ew;
        logic        el;
        if (digest_q.size() == 0) begin
            $display("%0t: unexpected digest word %h last %b", $time, dw, dl);
            errors++;
            return;
        end
        ew = digest_q.pop_front();
        el = last_q.pop_front();
        if (dw !== ew) begin
            $display("%0t: digest_word expected %h actual %h", $time, ew, dw);
            errors++;
        end
        if (dl !== el) begin
            $display("%0t: digest_last expected %b actual %b", $time, el, dl);
            errors++;
        end
    endfunction

endclass

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives random and directed messages into the SHA-512 engine and checks
// every digest word against a behavioral predictor, with random idling on
// both sides, a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_push = 1'b0;
    logic        o_full;
    logic [63:0] i_message_word = '0;
    logic [3:0]  i_valid_bytes = '0;
    logic        i_last_word = 1'b0;
    logic        o_empty;
    logic        i_pop = 1'b0;
    logic [63:0] o_digest_word;
    logic        o_digest_last;

    sha512_digest_board board = new();
    int unsigned cycle_cnt = 0;
    bit          calm = 1'b0;    // no idling on either side
    bit          hold_pop = 1'b0;

    localparam int unsigned CycleLimit = 400000;

    sha512_hash_engine_top u_top (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CycleLimit) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // receiver: check on handshake, then choose next pop
    always @(posedge i_clk) begin
        if (i_rst_n && i_pop && !o_empty) board.check_digest(o_digest_word, o_digest_last);
        i_pop <= i_rst_n && !hold_pop && (calm || $urandom_range(99) >= 17);
    end

    // push stays high between back-to-back items; idle cycles drop it
    task automatic send_word(logic [63:0] w, logic [3:0] vb, logic last);
        while (!calm && $urandom_range(99) < 17) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_message_word <= w;
        i_valid_bytes <= vb;
        i_last_word <= last;
        do @(posedge i_clk); while (o_full);
        board.note_word(w, vb, last);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_msg(int unsigned nfull, logic [3:0] vb);
        for (int i = 0; i < nfull; i++) send_word(rnd64(), 4'($urandom_range(15)), 1'b0);
        send_word(rnd64(), vb, 1'b1);
    endtask

    task automatic drain();
        i_push <= 1'b0;
        while (board.digest_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        int unsigned sent;
        int unsigned nf;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: empty message, extremes, each padding boundary
        send_word(64'h0, 4'd0, 1'b1);
        send_word(~64'h0, 4'd8, 1'b1);
        send_word(~64'h0, 4'd15, 1'b1);
        send_word(64'h6162630000000000, 4'd3, 1'b1);
        send_msg(13, 4'd8);
        send_msg(13, 4'd7);
        send_msg(14, 4'd0);
        send_word(~64'h0, 4'd9, 1'b0);
        send_word(64'h0, 4'd0, 1'b0);
        send_word(~64'h0, 4'd1, 1'b1);
        drain();
        // long output hold-off while input keeps coming
        hold_pop = 1'b1;
        fork
            begin
                for (int m = 0; m < 3; m++) send_msg(2, 4'd5);
            end
            begin
                int unsigned c;
                c = 0;
                while (c < 600) begin
                    @(posedge i_clk);
                    c++;
                end
                hold_pop = 1'b0;
            end
        join
        drain();
        // random messages, mostly short; one calm stretch
        sent = 0;
        while (sent < 200) begin
            calm = (sent > 60 && sent < 110);
            nf = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(17);
            send_msg(nf, 4'($urandom_range(15)));
            sent += nf + 1;
        end
        calm = 1'b0;
        drain();
        if (board.errors == 0 && board.digest_q.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
